FILE: rtl/core/cdda_pkg.sv
package cdda_pkg;

   localparam int unsigned YEAR_W  = 16;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned MOD25_W = 5;

   localparam logic OPCODE_LOAD    = 1'b0;
   localparam logic OPCODE_ADVANCE = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [YEAR_W-1:0]  YEAR_RESET  = 16'd0;
   localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
   localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;

   // floor(y / 25) == (y * MOD25_MAGIC) >> MOD25_SHIFT for every 16-bit y
   localparam logic [16:0] MOD25_MAGIC = 17'd83887;
   localparam int unsigned MOD25_SHIFT = 21;
   localparam logic [MOD25_W-1:0] MOD25_LAST = 5'd24;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
   } status_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      days = 5'd31;
      if (month == MONTH_FEB) begin
         days = leap ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         days = 5'd30;
      end
      return days;
   endfunction

endpackage

FILE: rtl/core/cdda_ctrl.sv
module cdda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cdda_pkg::status_type status,
   output cdda_pkg::cmd_type    cmd
);
   import cdda_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = (req_opcode == OPCODE_LOAD) ? ST_LOAD : ST_STEP;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DONE;
         end
         ST_STEP: begin
            if (status.count_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_step_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && status.count_zero) |=> (state_ff == ST_DONE))
      else $error("advance did not finish on zero count");

   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("not ready after response taken");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while response pending");

endmodule

FILE: rtl/core/cdda_dpath.sv
module cdda_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  cdda_pkg::cmd_type              cmd,
   output cdda_pkg::status_type           status,
   input  logic [cdda_pkg::YEAR_W-1:0]    req_load_year,
   input  logic [cdda_pkg::MONTH_W-1:0]   req_load_month,
   input  logic [cdda_pkg::DAY_W-1:0]     req_load_day,
   input  logic [cdda_pkg::COUNT_W-1:0]   req_day_count,
   output logic [cdda_pkg::YEAR_W-1:0]    rsp_cur_year,
   output logic [cdda_pkg::MONTH_W-1:0]   rsp_cur_month,
   output logic [cdda_pkg::DAY_W-1:0]     rsp_cur_day
);
   import cdda_pkg::*;

   logic [YEAR_W-1:0]  ld_year_ff;
   logic [MONTH_W-1:0] ld_month_ff;
   logic [DAY_W-1:0]   ld_day_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [MOD25_W-1:0] mod25_ff, mod25_in;

   logic [32:0]        ld_prod;
   logic [11:0]        ld_quot;
   logic [16:0]        ld_rem_full;
   logic               leap;
   logic [DAY_W:0]     next_day;
   logic [MOD25_W-1:0] mod25_inc;

   assign status.count_zero = (count_ff == '0);

   // year mod 25 of the loaded year by reciprocal multiply
   assign ld_prod     = 33'(ld_year_ff) * 33'(MOD25_MAGIC);
   assign ld_quot     = ld_prod[32:MOD25_SHIFT];
   assign ld_rem_full = 17'(ld_year_ff) - ((17'(ld_quot) << 4) + (17'(ld_quot) << 3)
                        + 17'(ld_quot));

   assign leap = (year_ff[1:0] == 2'b00) && ((mod25_ff != '0) || (year_ff[3:0] == 4'h0));
   assign next_day  = {1'b0, day_ff} + 6'd1;
   assign mod25_inc = (mod25_ff == MOD25_LAST) ? '0 : mod25_ff + 5'd1;

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      mod25_in = mod25_ff;
      if (cmd.load) begin
         year_in  = ld_year_ff;
         month_in = ld_month_ff;
         day_in   = ld_day_ff;
         mod25_in = ld_rem_full[MOD25_W-1:0];
      end else if (cmd.step) begin
         if (next_day > {1'b0, month_days(month_ff, leap)}) begin
            day_in = DAY_RESET;
            if (month_ff >= MONTH_DEC) begin
               month_in = MONTH_RESET;
               year_in  = year_ff + 16'd1;
               // wrap of 65535 to 0 lands on a multiple of 25
               mod25_in = (year_ff == '1) ? '0 : mod25_inc;
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            day_in = next_day[DAY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ld_year_ff  <= req_load_year;
         ld_month_ff <= req_load_month;
         ld_day_ff   <= req_load_day;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         year_ff  <= YEAR_RESET;
         month_ff <= MONTH_RESET;
         day_ff   <= DAY_RESET;
         mod25_ff <= '0;
      end else begin
         if (cmd.capture) begin
            count_ff <= req_day_count;
         end else if (cmd.step) begin
            count_ff <= count_ff - 16'd1;
         end
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         mod25_ff <= mod25_in;
      end
   end

   assign rsp_cur_year  = year_ff;
   assign rsp_cur_month = month_ff;
   assign rsp_cur_day   = day_ff;

   a_mod25_range: assert property (@(posedge clock) disable iff (reset)
      mod25_ff <= MOD25_LAST)
      else $error("year residue out of range");

   a_step_day: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (day_ff != '0))
      else $error("day zero after a step");

endmodule

FILE: rtl/core/calendar_date_day_advancer.sv
// Calendar date keeper with a day advancer.
// Request channel (req_valid/req_ready): req_opcode selects a load of
// req_load_year/month/day as given, or an advance by req_day_count days.
// Response channel (rsp_valid/rsp_ready): one response per request carries
// the date after the operation in rsp_cur_year/month/day.
// One request is in flight at a time; req_ready is high only while idle.
// After a request is accepted, a load passes through the load state and an
// advance through the step state, which repeats until the day count is zero,
// before the response turns valid in the done state.
// The next request can be taken in the cycle after the response is accepted.
// The date advances by one day per cycle in a single step unit; that
// loop sets the advance time. Leap years follow the Gregorian rule,
// using a year-mod-25 residue kept beside the year.
// Reset (synchronous, active high) sets the date to year 0, month 1, day 1
// and returns to idle.
// While the receiver stalls, the response and the date hold, and no new
// request is taken until the response is accepted.
module calendar_date_day_advancer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [cdda_pkg::YEAR_W-1:0]   req_load_year,
   input  logic [cdda_pkg::MONTH_W-1:0]  req_load_month,
   input  logic [cdda_pkg::DAY_W-1:0]    req_load_day,
   input  logic [cdda_pkg::COUNT_W-1:0]  req_day_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cdda_pkg::YEAR_W-1:0]   rsp_cur_year,
   output logic [cdda_pkg::MONTH_W-1:0]  rsp_cur_month,
   output logic [cdda_pkg::DAY_W-1:0]    rsp_cur_day
);
   import cdda_pkg::*;

   cmd_type    cmd;
   status_type status;

   cdda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   cdda_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_load_year  (req_load_year),
      .req_load_month (req_load_month),
      .req_load_day   (req_load_day),
      .req_day_count  (req_day_count),
      .rsp_cur_year   (rsp_cur_year),
      .rsp_cur_month  (rsp_cur_month),
      .rsp_cur_day    (rsp_cur_day)
   );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 25_000_000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [cdda_pkg::YEAR_W-1:0]  year;
      logic [cdda_pkg::MONTH_W-1:0] month;
      logic [cdda_pkg::DAY_W-1:0]   day;
   } calendar_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = cdda_pkg::OPCODE_LOAD;
   logic [cdda_pkg::YEAR_W-1:0]   req_load_year = '0;
   logic [cdda_pkg::MONTH_W-1:0]  req_load_month = '0;
   logic [cdda_pkg::DAY_W-1:0]    req_load_day = '0;
   logic [cdda_pkg::COUNT_W-1:0]  req_day_count = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [cdda_pkg::YEAR_W-1:0]   rsp_cur_year;
   logic [cdda_pkg::MONTH_W-1:0]  rsp_cur_month;
   logic [cdda_pkg::DAY_W-1:0]    rsp_cur_day;

   calendar_type   held_date;
   calendar_type   expected_dates[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             hold_requests = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   int             stall_phase = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   calendar_date_day_advancer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_load_year  (req_load_year),
      .req_load_month (req_load_month),
      .req_load_day   (req_load_day),
      .req_day_count  (req_day_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cur_year   (rsp_cur_year),
      .rsp_cur_month  (rsp_cur_month),
      .rsp_cur_day    (rsp_cur_day)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_leap(logic [cdda_pkg::YEAR_W-1:0] year);
      return ((year % 400) == 0) || (((year % 100) != 0) && ((year % 4) == 0));
   endfunction

   function automatic logic [5:0] days_in_month(logic [cdda_pkg::YEAR_W-1:0] year,
                                                logic [cdda_pkg::MONTH_W-1:0] month);
      if (month == cdda_pkg::MONTH_FEB) begin
         return is_leap(year) ? 6'd29 : 6'd28;
      end
      if (month == cdda_pkg::MONTH_APR || month == cdda_pkg::MONTH_JUN ||
          month == cdda_pkg::MONTH_SEP || month == cdda_pkg::MONTH_NOV) begin
         return 6'd30;
      end
      return 6'd31;
   endfunction

   function automatic calendar_type advance_date(calendar_type start,
                                                 logic [cdda_pkg::COUNT_W-1:0] days);
      calendar_type date;
      logic [5:0]   next_day;
      logic [4:0]   next_month;
      date = start;
      for (int i = 0; i < days; i++) begin
         next_day = {1'b0, date.day} + 6'd1;
         if (next_day > days_in_month(date.year, date.month)) begin
            next_month = {1'b0, date.month} + 5'd1;
            date.day = 5'd1;
            if (next_month > {1'b0, cdda_pkg::MONTH_DEC}) begin
               date.month = 4'd1;
               date.year = date.year + 16'd1;
            end else begin
               date.month = next_month[3:0];
            end
         end else begin
            date.day = next_day[4:0];
         end
      end
      return date;
   endfunction

   task automatic send_request(input logic opcode,
                               input logic [cdda_pkg::YEAR_W-1:0] year,
                               input logic [cdda_pkg::MONTH_W-1:0] month,
                               input logic [cdda_pkg::DAY_W-1:0] day,
                               input logic [cdda_pkg::COUNT_W-1:0] count);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_opcode     <= opcode;
      req_load_year  <= year;
      req_load_month <= month;
      req_load_day   <= day;
      req_day_count  <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (opcode == cdda_pkg::OPCODE_LOAD) begin
         held_date = '{year: year, month: month, day: day};
      end else begin
         held_date = advance_date(held_date, count);
      end
      expected_dates.push_back(held_date);
   endtask

   task automatic load_date(input int year, input int month, input int day);
      send_request(cdda_pkg::OPCODE_LOAD, 16'(year), 4'(month), 5'(day), 16'($urandom));
   endtask

   task automatic advance_days(input int days);
      send_request(cdda_pkg::OPCODE_ADVANCE, 16'($urandom), 4'($urandom), 5'($urandom),
                   16'(days));
   endtask

   task automatic test_reset_date();
      send_request(cdda_pkg::OPCODE_ADVANCE, '1, '1, '1, '0);
   endtask

   task automatic test_load_extremes();
      send_request(cdda_pkg::OPCODE_LOAD, '0, '0, '0, '1);
      send_request(cdda_pkg::OPCODE_LOAD, '1, '1, '1, '0);
   endtask

   task automatic test_odd_loads();
      load_date(2023, 0, 0);
      advance_days(1);
      advance_days(30);
      advance_days(1);
      load_date(2023, 15, 31);
      advance_days(1);
   endtask

   task automatic test_month_ends();
      load_date(2023, 4, 30);
      advance_days(1);
      load_date(2023, 2, 31);
      advance_days(1);
      load_date(2023, 12, 31);
      advance_days(1);
   endtask

   task automatic test_leap_years();
      load_date(2024, 2, 28);
      advance_days(1);
      load_date(1900, 2, 28);
      advance_days(1);
      load_date(2000, 2, 28);
      advance_days(1);
      advance_days(1);
   endtask

   task automatic test_year_wrap();
      load_date(65535, 12, 31);
      advance_days(1);
   endtask

   task automatic test_max_count();
      load_date(1999, 1, 1);
      advance_days(65535);
   endtask

   task automatic test_receiver_hold();
      hold_requests <= hold_requests + 1;
      burst_left = 8;
      for (int i = 0; i < 6; i++) begin
         if (i % 2 == 0) load_date($urandom, $urandom_range(1, 12), $urandom_range(1, 28));
         else advance_days($urandom_range(0, 60));
      end
   endtask

   function automatic int pick_year();
      unique case ($urandom_range(0, 7))
         0: return 1600;
         1: return 1900;
         2: return 2000;
         3: return 2100;
         4: return 65535;
         5: return $urandom_range(1896, 2404);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic test_random_dates();
      int pick;
      int year;
      int month;
      int count;
      for (int i = 0; i < 70; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            year = pick_year();
            month = $urandom_range(1, 12);
            load_date(year, month, $urandom_range(1, days_in_month(16'(year), 4'(month))));
         end else if (pick < 35) begin
            send_request(cdda_pkg::OPCODE_LOAD, 16'($urandom), 4'($urandom), 5'($urandom),
                         16'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) count = $urandom_range(0, 65535);
            else if (pick < 10) count = $urandom_range(0, 5000);
            else if (pick < 40) count = $urandom_range(0, 800);
            else count = $urandom_range(0, 40);
            advance_days(count);
         end
      end
   endtask

   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_phase <= stall_phase + 1;
         unique case (ready_mode)
            READY_ALWAYS:   rsp_ready <= 1'b1;
            READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: rsp_ready <= stall_phase[2];
            default:        rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      calendar_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0d-%0d-%0d",
                     $time, rsp_cur_year, rsp_cur_month, rsp_cur_day);
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            if (rsp_cur_year !== want.year) begin
               $display("%0t: year mismatch, expected %0d, actual %0d",
                        $time, want.year, rsp_cur_year);
               error_count++;
            end
            if (rsp_cur_month !== want.month) begin
               $display("%0t: month mismatch, expected %0d, actual %0d",
                        $time, want.month, rsp_cur_month);
               error_count++;
            end
            if (rsp_cur_day !== want.day) begin
               $display("%0t: day mismatch, expected %0d, actual %0d",
                        $time, want.day, rsp_cur_day);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      held_date = '{year: cdda_pkg::YEAR_RESET, month: cdda_pkg::MONTH_RESET,
                    day: cdda_pkg::DAY_RESET};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_date();
      test_load_extremes();
      test_odd_loads();
      test_month_ends();
      test_leap_years();
      test_year_wrap();
      test_max_count();
      test_receiver_hold();
      test_random_dates();
      req_valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      // let any stray response show up
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
